### rtl/rfd_pkg.sv
// Shared types and constants for the remote control frame decoder.
package rfd_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned FRAMES_W  = 7;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned OUT_W     = 160;

  localparam logic [FRAMES_W-1:0] REBOOT_FRAMES_RST = 7'd70;
  localparam logic [MASK_W-1:0]   CHORD_MASK_RST    = 16'h0420;
  localparam logic [FRAMES_W-1:0] CHORD_MAX         = 7'd127;

  // Register index on the configuration port (word address bit 2)
  localparam logic REG_REBOOT_FRAMES = 1'b0;
  localparam logic REG_CHORD_MASK    = 1'b1;

  // Input item kind
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_IDLE = 1'b1;

  // Switch s2 positions
  localparam logic [1:0] SW_HOLD   = 2'd0;
  localparam logic [1:0] SW_MOUSE  = 2'd1;
  localparam logic [1:0] SW_STOP   = 2'd2;
  localparam logic [1:0] SW_REMOTE = 2'd3;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_REMOTE   = 2'd1,
    MODE_MOUSEKEY = 2'd2
  } mode_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // First member sits in the top bits, so sticks ends up at bit 0
  typedef struct packed {
    logic              reboot_request;
    logic [15:0]       key_toggles;
    logic [1:0]        input_mode;
    logic [15:0]       key_word;
    logic [15:0]       mouse_buttons;
    logic signed [15:0] mouse_z;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_x;
    logic [1:0]        switch_right;
    logic [1:0]        switch_left;
    logic [5*CH_W-1:0] sticks;
  } result_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] reboot_frames;
    logic [MASK_W-1:0]   chord_mask;
  } cfg_t;

endpackage

### rtl/rfd_frame_buf.sv
// Byte counter and 18-byte frame store.
module rfd_frame_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_wr,
  input  logic                 idle_evt,
  input  logic [7:0]           rx_byte,
  output logic                 full,
  output rfd_pkg::frame_t      frame
);

  logic [rfd_pkg::CNT_W-1:0] count_r;
  logic [rfd_pkg::CNT_W-1:0] count_nxt;
  rfd_pkg::frame_t           frame_r;

  assign full  = (count_r >= rfd_pkg::CNT_W'(rfd_pkg::FRAME_LEN));
  assign frame = frame_r;

  always_comb begin
    count_nxt = count_r;
    if (idle_evt) begin
      count_nxt = '0;
    end else if (byte_wr && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Store has no reset; entries are only read once a full frame is in
  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(rfd_pkg::FRAME_LEN); i++) begin
      if (byte_wr && !full && count_r == rfd_pkg::CNT_W'(i)) begin
        frame_r[i] <= rx_byte;
      end
    end
  end

endmodule

### rtl/rfd_decode.sv
// Frame field unpacking, mode, key toggles and reboot chord tracking.
module rfd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  rfd_pkg::frame_t    frame,
  input  rfd_pkg::cfg_t      cfg,
  output rfd_pkg::result_t   result
);

  rfd_pkg::mode_t                 mode_r, mode_nxt;
  logic [15:0]                    prev_key_r, toggle_r, toggle_nxt;
  logic [rfd_pkg::FRAMES_W-1:0]   chord_r, chord_nxt;
  logic [15:0]                    keys;
  logic [1:0]                     s2;
  logic                           chord_hit;

  assign keys = {frame[15], frame[14]};
  assign s2   = frame[5][5:4];

  always_comb begin
    case (s2)
      rfd_pkg::SW_STOP:   mode_nxt = rfd_pkg::MODE_STOP;
      rfd_pkg::SW_REMOTE: mode_nxt = rfd_pkg::MODE_REMOTE;
      rfd_pkg::SW_MOUSE:  mode_nxt = rfd_pkg::MODE_MOUSEKEY;
      default:            mode_nxt = mode_r;
    endcase
  end

  // Toggles follow rising key bits, using the mode after this frame
  assign toggle_nxt = (mode_nxt != rfd_pkg::MODE_STOP) ?
                      (toggle_r ^ (keys & ~prev_key_r)) : toggle_r;

  assign chord_hit = (s2 == rfd_pkg::SW_STOP) && ((keys & cfg.chord_mask) == cfg.chord_mask);

  always_comb begin
    if (!chord_hit) begin
      chord_nxt = '0;
    end else if (chord_r < rfd_pkg::CHORD_MAX) begin
      chord_nxt = chord_r + 1'b1;
    end else begin
      chord_nxt = chord_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rfd_pkg::MODE_STOP;
      prev_key_r <= '0;
      toggle_r   <= '0;
      chord_r    <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      prev_key_r <= keys;
      toggle_r   <= toggle_nxt;
      chord_r    <= chord_nxt;
    end
  end

  always_comb begin
    result.sticks         = {frame[17][2:0], frame[16],
                             frame[5][3:0], frame[4][7:1],
                             frame[4][0], frame[3], frame[2][7:6],
                             frame[2][5:0], frame[1][7:3],
                             frame[1][2:0], frame[0]};
    result.switch_left    = frame[5][7:6];
    result.switch_right   = s2;
    result.mouse_x        = {frame[7], frame[6]};
    result.mouse_y        = {frame[9], frame[8]};
    result.mouse_z        = {frame[11], frame[10]};
    result.mouse_buttons  = {frame[13], frame[12]};
    result.key_word       = keys;
    result.input_mode     = mode_nxt;
    result.key_toggles    = toggle_nxt;
    result.reboot_request = (chord_nxt >= cfg.reboot_frames);
  end

endmodule

### rtl/remote_frame_decoder.sv
// Remote control frame decoder: top level with config port and result register.
// One request (a received byte or a line-idle event) is taken per clock. A
// byte goes into the frame store; an idle event on a frame of 18 or more bytes
// is decoded in the same cycle and the result appears on the out_ channel the
// next cycle, held in a single result register. in_tready drops only while
// that register holds a result that the sink has not taken, so with out_tready
// high the block runs at one request per cycle.
// Idle events on shorter frames give no result. Bytes past the 18th are dropped.
module remote_frame_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic         in_tuser,   // [0] func: 0 byte, 1 line idle
  output logic         out_tvalid,
  input  logic         out_tready,
  // [54:0] sticks, [56:55] switch_left, [58:57] switch_right, [74:59] mouse_x,
  // [90:75] mouse_y, [106:91] mouse_z, [122:107] mouse_buttons,
  // [138:123] key_word, [140:139] input_mode, [156:141] key_toggles,
  // [157] reboot_request, [159:158] zero
  output logic [159:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  rfd_pkg::cfg_t    cfg_r;
  rfd_pkg::frame_t  frame;
  rfd_pkg::result_t result;
  rfd_pkg::result_t res_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc, byte_wr, idle_evt, full, fire, cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reboot_frames <= rfd_pkg::REBOOT_FRAMES_RST;
      cfg_r.chord_mask    <= rfd_pkg::CHORD_MASK_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        rfd_pkg::REG_REBOOT_FRAMES: cfg_r.reboot_frames <= cfg_pwdata[rfd_pkg::FRAMES_W-1:0];
        rfd_pkg::REG_CHORD_MASK:    cfg_r.chord_mask    <= cfg_pwdata[rfd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      rfd_pkg::REG_REBOOT_FRAMES: cfg_prdata = 32'(cfg_r.reboot_frames);
      rfd_pkg::REG_CHORD_MASK:    cfg_prdata = 32'(cfg_r.chord_mask);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign byte_wr   = in_acc && (in_tuser == rfd_pkg::FUNC_BYTE);
  assign idle_evt  = in_acc && (in_tuser == rfd_pkg::FUNC_IDLE);
  assign fire      = idle_evt && full;

  rfd_frame_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_wr  (byte_wr),
    .idle_evt (idle_evt),
    .rx_byte  (in_tdata),
    .full     (full),
    .frame    (frame)
  );

  rfd_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .frame  (frame),
    .cfg    (cfg_r),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

### rtl/rfd_checker.sv
// Port-level checks for the remote control frame decoder, bound to the top level.
module rfd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing waiting means the input side is open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // A received byte never produces a result
  a_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tvalid && in_tready && !in_tuser |=> !out_tvalid)
    else $error("result raised by a received byte");

  // Mode follows a non-zero s2 position in the same frame
  a_mode_sw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[58:57] == 2'd0) ||
      (out_tdata[58:57] == 2'd2 && out_tdata[140:139] == 2'd0) ||
      (out_tdata[58:57] == 2'd3 && out_tdata[140:139] == 2'd1) ||
      (out_tdata[58:57] == 2'd1 && out_tdata[140:139] == 2'd2))
    else $error("input mode does not match switch s2");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind remote_frame_decoder rfd_checker u_rfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
